>>> design/cfpt_pkg.sv
`default_nettype none
package cfpt_pkg;
  localparam int FrameBytes = 7;
  localparam logic [7:0] Marker = 8'd2;
  localparam logic [7:0] Invalid = 8'd255;
  localparam int AtanEntries = 24;
  localparam logic [25:0] FullTurn = 26'd23592960;
  localparam logic [25:0] HalfTurn = 26'd11796480;
  localparam logic [15:0] ZeroBearing = 16'd9000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_CORDIC, ST_ROUND, ST_NEXT, ST_DONE
  } cfpt_state_t;

  typedef struct packed {
    logic load;
    logic sel_second;
    logic step;
    logic round;
    logic store_first;
  } cfpt_cmd_t;

  typedef struct packed {
    logic last_step;
  } cfpt_stat_t;

  function automatic logic [22:0] atan_entry(input logic [4:0] i);
    logic [22:0] r;
    begin
      case (i)
        5'd0: r = 23'd2949120;  5'd1: r = 23'd1740967;
        5'd2: r = 23'd919879;   5'd3: r = 23'd466945;
        5'd4: r = 23'd234379;   5'd5: r = 23'd117304;
        5'd6: r = 23'd58666;    5'd7: r = 23'd29335;
        5'd8: r = 23'd14668;    5'd9: r = 23'd7334;
        5'd10: r = 23'd3667;    5'd11: r = 23'd1833;
        5'd12: r = 23'd917;     5'd13: r = 23'd458;
        5'd14: r = 23'd229;     5'd15: r = 23'd115;
        5'd16: r = 23'd57;      5'd17: r = 23'd29;
        5'd18: r = 23'd14;      5'd19: r = 23'd7;
        5'd20: r = 23'd4;       5'd21: r = 23'd2;
        5'd22: r = 23'd1;       default: r = 23'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

>>> design/camera_frame_to_polar_targets_top.sv
`default_nettype none
// Per target: load, max(CORDIC_STEPS,17) shared CORDIC/root steps (17-step root is the
// floor), round and turn states; both targets share one CORDIC and one bit-serial root.
// One frame in flight; the next request can be taken in the same cycle that m_tvalid
// rises, and a held result only delays the following result.
// Reset (rst, synchronous): aligned frame cleared to zeros, register to 0.
module camera_frame_to_polar_targets_top
  import cfpt_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata, // raw_byte_0..raw_byte_6
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata, // own v,ang,dist, opp v,ang,dist, lw v,off, rw v,off, mf
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic yellow;
  logic [7:0] frame [FrameBytes];
  logic [7:0] raw [FrameBytes];
  logic [7:0] rot [FrameBytes];
  logic [2:0] pos;
  logic found, mf;
  cfpt_cmd_t cmd;
  cfpt_stat_t stat;
  logic busy, done, start;
  logic v0, v1;
  logic [15:0] a0, a1, d0, d1;

  assign pready = 1'b1;
  assign prdata = {31'd0, yellow};
  always_ff @(posedge clk) begin
    if (rst) yellow <= 1'b0;
    else if (psel && penable && pwrite && paddr == 1'b0) yellow <= pwdata[0];
  end

  always_comb begin
    found = 1'b0;
    pos = '0;
    for (int i = 0; i < FrameBytes; i++) begin
      raw[i] = s_tdata[8*i +: 8];
      if (raw[i] == Marker) begin
        found = 1'b1;
        pos = 3'(i);
      end
    end
  end

  // Raw frame rotated so the last marker lands in byte 0.
  always_comb begin
    logic [3:0] k;
    for (int j = 0; j < FrameBytes; j++) begin
      k = {1'b0, pos} + 4'(j);
      if (k >= 4'(FrameBytes)) k = k - 4'(FrameBytes);
      rot[j] = raw[k[2:0]];
    end
  end

  // The output register parts the sides: a waiting result does not block a request.
  assign s_tready = !busy;
  assign start = s_tvalid && s_tready;

  // Aligned frame for this request: the rotated raw frame when a marker is
  // present, else the stored one. Held for the whole compute.
  logic [7:0] use_f [FrameBytes];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < FrameBytes; j++) frame[j] <= 8'd0;
    end else if (start && found) begin
      for (int j = 0; j < FrameBytes; j++)
        frame[j] <= rot[j];
    end
    if (start) begin
      mf <= found;
      for (int j = 0; j < FrameBytes; j++)
        use_f[j] <= (found) ? rot[j] : frame[j];
    end
  end

  cfpt_ctrl u_ctrl (
    .clk, .rst, .start, .out_free(!m_tvalid), .stat, .cmd, .busy, .done
  );

  cfpt_dp #(.CordicSteps(CORDIC_STEPS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .x0(yellow ? use_f[1] : use_f[3]), .y0(yellow ? use_f[2] : use_f[4]),
    .x1(yellow ? use_f[3] : use_f[1]), .y1(yellow ? use_f[4] : use_f[2]),
    .v0, .ang0(a0), .dist0(d0), .v1, .ang1(a1), .dist1(d1)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (done) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {2'd0, mf,
        (use_f[6] == Invalid) ? 8'd0 : use_f[6] - 8'd128, use_f[6] != Invalid,
        (use_f[5] == Invalid) ? 9'd0 : 9'd128 - {1'b0, use_f[5]}, use_f[5] != Invalid,
        d1, a1, v1, d0, a0, v0};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result changed");
  a_done: assert property (@(posedge clk) disable iff (rst) done |=> m_tvalid)
    else $error("result lost");
endmodule
`default_nettype wire

>>> design/cfpt_ctrl.sv
`default_nettype none
module cfpt_ctrl
  import cfpt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      out_free,
  input  var  cfpt_stat_t stat,
  output var  cfpt_cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  cfpt_state_t state, state_next;
  logic second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      second <= 1'b0;
    end else begin
      state <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next = state;
    second_next = second;
    cmd = '0;
    cmd.sel_second = second;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_LOAD;
          second_next = 1'b0;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.step = 1'b1;
        if (stat.last_step) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.store_first = !second;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (second) state_next = ST_DONE;
        else begin
          second_next = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> design/cfpt_dp.sv
`default_nettype none
module cfpt_dp
  import cfpt_pkg::*;
#(
  parameter int CordicSteps = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  var  cfpt_cmd_t  cmd,
  output var  cfpt_stat_t stat,
  input  wire logic [7:0] x0,
  input  wire logic [7:0] y0,
  input  wire logic [7:0] x1,
  input  wire logic [7:0] y1,
  output logic            v0,
  output logic [15:0]     ang0,
  output logic [15:0]     dist0,
  output logic            v1,
  output logic [15:0]     ang1,
  output logic [15:0]     dist1
);
  localparam int CW = 24;
  localparam int IW = $clog2(CordicSteps + 1);
  logic signed [CW-1:0] u, v;
  logic signed [27:0] z;
  logic [IW-1:0] it;
  logic [16:0] rad;
  logic zero, inval;
  logic [7:0] x, y;
  logic signed [8:0] dx, dy;
  logic signed [CW-1:0] us, vs;
  logic [22:0] at;
  logic signed [28:0] zw;
  logic [27:0] t;
  logic [34:0] hp;
  logic [15:0] h;
  logic [16:0] dr;

  assign x = cmd.sel_second ? x1 : x0;
  assign y = cmd.sel_second ? y1 : y0;
  assign dx = $signed({1'b0, x}) - 9'sd128;
  assign dy = 9'sd128 - $signed({1'b0, y});
  assign us = u >>> it;
  assign vs = v >>> it;
  assign at = atan_entry(5'(it));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inval <= (x == Invalid) || (y == Invalid);
      zero <= (dx == 0) && (dy == 0);
      it <= '0;
      if (dy < 0) begin
        u <= -(CW'(dy) <<< 12);
        v <= -(CW'(dx) <<< 12);
        z <= 28'(HalfTurn);
      end else begin
        u <= CW'(dy) <<< 12;
        v <= CW'(dx) <<< 12;
        z <= '0;
      end
      rad <= 17'(dx * dx) + 17'(dy * dy);
    end else if (cmd.step && it != IW'(CordicSteps)) begin
      it <= it + 1'b1;
      if (v >= 0) begin
        u <= u + vs; v <= v - us; z <= z + $signed({5'd0, at});
      end else begin
        u <= u - vs; v <= v + us; z <= z - $signed({5'd0, at});
      end
    end
  end

  // square root of rad<<16 (34 bits -> 17 result bits), 17 steps alongside the cordic
  logic [4:0] sq_i;
  logic [35:0] sq_rem;
  logic [16:0] sq_r;
  logic [35:0] sq_t;
  logic [33:0] sq_n;
  logic [1:0] pair;
  assign sq_n = {1'b0, rad, 16'd0};
  // step phase ends once both the cordic and the root have reached or passed their last step
  assign stat.last_step = (it >= IW'(CordicSteps - 1)) && (sq_i == 5'd0 || sq_i == 5'h1f);
  always_comb begin
    pair = (sq_i <= 5'd16) ? sq_n[{sq_i, 1'b1} -: 2] : 2'b00;
    sq_t = {sq_rem[33:0], pair};
  end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_i <= 5'd16;
      sq_rem <= '0;
      sq_r <= '0;
    end else if (cmd.step) begin
      if (sq_i != 5'h1f) begin
        sq_i <= sq_i - 1'b1;
        if (sq_t >= {17'd0, sq_r, 2'b01}) begin
          sq_rem <= sq_t - {17'd0, sq_r, 2'b01};
          sq_r <= {sq_r[15:0], 1'b1};
        end else begin
          sq_rem <= sq_t;
          sq_r <= {sq_r[15:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    zw = {z[27], z};
    if (zw < 0) zw = zw + $signed({3'd0, FullTurn});
    if (zw >= $signed({3'd0, FullTurn})) zw = zw - $signed({3'd0, FullTurn});
    t = 28'(zw);
    hp = 35'(t) * 35'd100 + 35'd32768;
    h = 16'(hp >> 16);
    if (h >= 16'd36000) h = h - 16'd36000;
    if (zero) h = ZeroBearing;
    dr = (sq_rem[35:0] > {19'd0, sq_r}) ? sq_r + 1'b1 : sq_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0;
    end else if (cmd.round) begin
      if (cmd.store_first) begin
        v0 <= !inval;
        ang0 <= inval ? 16'd0 : h;
        dist0 <= inval ? 16'd0 : dr[15:0];
      end else begin
        v1 <= !inval;
        ang1 <= inval ? 16'd0 : h;
        dist1 <= inval ? 16'd0 : dr[15:0];
      end
    end
  end
endmodule
`default_nettype wire

>>> dv/camera_frame_to_polar_targets_top_tb.sv
`timescale 1ns / 1ps
module camera_frame_to_polar_targets_top_tb;
  import cfpt_pkg::*;

  localparam int Steps = 16;
  localparam int SqrtSteps = 17;
  localparam int LatencyCycles = 2 * (((Steps > SqrtSteps) ? Steps : SqrtSteps) + 3) + 1;
  localparam int RegYellow = 0;  // register index of yellow_is_own_goal

  // One decoded result, kept at the block's field widths.
  typedef struct {
    logic        own_v;
    logic [15:0] own_ang;
    logic [15:0] own_dist;
    logic        opp_v;
    logic [15:0] opp_ang;
    logic [15:0] opp_dist;
    logic        lw_v;
    logic [8:0]  lw_off;
    logic        rw_v;
    logic [7:0]  rw_off;
    logic        mf;
  } targets_t;

  // Directed stimulus row. Rows marked typed carry a hand-written result;
  // their angles still come from the polar predictor unless pinned.
  typedef struct {
    logic [55:0] frame;
    bit          typed;
    bit          pin_angle;
    targets_t    res;
  } frame_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;     // raw_byte_0 .. raw_byte_6
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [87:0]  m_tdata;          // own v,ang,dist, opp v,ang,dist, lw v,off, rw v,off, mf
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [0:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  camera_frame_to_polar_targets_top #(.CORDIC_STEPS(Steps)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the aligned frame and the goal swap.
  // ---------------------------------------------------------------------
  logic [7:0] frame_copy [FrameBytes];
  logic       yellow_own;
  targets_t   targets_q [$];
  int         errors = 0;
  int         results_seen = 0;
  int         frames_sent = 0;
  int         frames_unmarked = 0;
  int         cfg_writes = 0;
  bit         hold_go = 0;

  // atan(2^-i) in 2^-16 degree units
  longint atan_lut [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                            58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                            229, 115};

  function automatic logic [15:0] bearing_cdeg(longint dx, longint dy);
    longint u, v, z, us, vs, t, h;
    u = dy * 4096;
    v = dx * 4096;
    z = 0;
    if (dx == 0 && dy == 0) return ZeroBearing;
    if (u < 0) begin
      u = -u;
      v = -v;
      z = 180 * 65536;
    end
    for (int i = 0; i < Steps; i++) begin
      us = u >>> i;   // arithmetic shift floors
      vs = v >>> i;
      if (v >= 0) begin
        u = u + vs; v = v - us; z = z + atan_lut[i];
      end else begin
        u = u - vs; v = v + us; z = z - atan_lut[i];
      end
    end
    t = z;
    while (t < 0) t = t + 360 * 65536;
    while (t >= 360 * 65536) t = t - 360 * 65536;
    h = (t * 100 + 32768) >> 16;
    if (h >= 36000) h = h - 36000;
    return h[15:0];
  endfunction

  // Rounded integer square root (bitwise, exact).
  function automatic logic [15:0] root_nearest(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 40;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r++;
    return r[15:0];
  endfunction

  task automatic polar_point(input logic [7:0] x, input logic [7:0] y, output logic vld,
                             output logic [15:0] ang, output logic [15:0] rng);
    longint dx, dy;
    if (x == Invalid || y == Invalid) begin
      vld = 0; ang = 0; rng = 0;
    end else begin
      dx = longint'(x) - 128;
      dy = 128 - longint'(y);
      vld = 1;
      ang = bearing_cdeg(dx, dy);
      rng = root_nearest(longint'(dx * dx + dy * dy) << 16);
    end
  endtask

  // Aligns one raw frame into the stored copy and predicts the targets.
  task automatic predict_targets(input logic [55:0] raw, output targets_t r);
    int pos;
    logic [7:0] b [FrameBytes];
    pos = -1;
    for (int i = 0; i < FrameBytes; i++) begin
      b[i] = raw[8*i +: 8];
      if (b[i] == Marker) pos = i;   // last marker wins
    end
    if (pos >= 0)
      for (int j = 0; j < FrameBytes; j++) frame_copy[j] = b[(pos + j) % FrameBytes];
    if (yellow_own) begin
      polar_point(frame_copy[1], frame_copy[2], r.own_v, r.own_ang, r.own_dist);
      polar_point(frame_copy[3], frame_copy[4], r.opp_v, r.opp_ang, r.opp_dist);
    end else begin
      polar_point(frame_copy[3], frame_copy[4], r.own_v, r.own_ang, r.own_dist);
      polar_point(frame_copy[1], frame_copy[2], r.opp_v, r.opp_ang, r.opp_dist);
    end
    r.lw_v = (frame_copy[5] != Invalid);
    r.lw_off = r.lw_v ? 9'(128 - int'(frame_copy[5])) : '0;
    r.rw_v = (frame_copy[6] != Invalid);
    r.rw_off = r.rw_v ? 8'(int'(frame_copy[6]) - 128) : '0;
    r.mf = (pos >= 0);
  endtask

  // ---------------------------------------------------------------------
  // Result checker: every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    targets_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (targets_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        e = targets_q.pop_front();
        check_field("own_goal_valid", e.own_v, m_tdata[0]);
        check_field("own_goal_angle", e.own_ang, m_tdata[16:1]);
        check_field("own_goal_distance", e.own_dist, m_tdata[32:17]);
        check_field("opp_goal_valid", e.opp_v, m_tdata[33]);
        check_field("opp_goal_angle", e.opp_ang, m_tdata[49:34]);
        check_field("opp_goal_distance", e.opp_dist, m_tdata[65:50]);
        check_field("left_wall_valid", e.lw_v, m_tdata[66]);
        check_field("left_wall_offset", e.lw_off, m_tdata[75:67]);
        check_field("right_wall_valid", e.rw_v, m_tdata[76]);
        check_field("right_wall_offset", e.rw_off, m_tdata[84:77]);
        check_field("marker_found", e.mf, m_tdata[85]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stalls on its own pattern; a hold request forces a long
  // stall so the block backs up and drops s_tready.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    int hold_left;
    int mode;
    if (rst) begin
      hold_left = 0;
      mode = 0;
      m_tready <= 1'b0;
    end else begin
      if (hold_go) begin
        hold_go = 0;
        hold_left = 400;
      end
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;                              // no stalls
          1: m_tready <= $urandom_range(0, 1);              // coin flip
          2: m_tready <= ($urandom_range(0, 7) == 0);       // mostly stalled
          default: m_tready <= ($time / 20) % 5 != 0;       // periodic
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender: bursts of requests with random gaps between them.
  // ---------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_frame(input logic [55:0] raw, input frame_row_t row, input bit use_row);
    targets_t r;
    int gap;
    s_tdata <= raw;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_targets(raw, r);
    if (use_row && row.typed) begin
      row.res.own_ang = row.pin_angle ? row.res.own_ang : r.own_ang;
      row.res.opp_ang = row.pin_angle ? row.res.opp_ang : r.opp_ang;
      r = row.res;
    end
    targets_q.push_back(r);
    frames_sent++;
    if (!r.mf) frames_unmarked++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write with the block idle: stop offering requests, drain
  // results, then let any work in flight finish.
  task automatic write_reg(input int idx, input logic [31:0] val);
    s_tvalid <= 1'b0;
    while (targets_q.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 4) @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 1'(idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegYellow) yellow_own = val[0];
    cfg_writes++;
  endtask

  function automatic logic [55:0] pack_frame(input logic [7:0] b0, b1, b2, b3, b4, b5, b6);
    return {b6, b5, b4, b3, b2, b1, b0};
  endfunction

  // Random frame: mostly a well-formed frame rotated by a random amount,
  // the rest frames with no marker, several markers or pure noise.
  function automatic logic [55:0] random_frame();
    logic [7:0] a [FrameBytes];
    logic [55:0] f;
    int rot, kind;
    kind = $urandom_range(0, 99);
    a[0] = Marker;
    for (int i = 1; i < FrameBytes; i++) begin
      a[i] = ($urandom_range(0, 9) == 0) ? Invalid :
             ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255) :
             8'($urandom_range(0, 255));
      if (kind < 75 && a[i] == Marker) a[i] = 8'd3;
    end
    rot = $urandom_range(0, FrameBytes - 1);
    for (int i = 0; i < FrameBytes; i++) f[8*((i + rot) % FrameBytes) +: 8] = a[i];
    if (kind >= 75 && kind < 85) begin
      for (int i = 0; i < FrameBytes; i++)
        if (f[8*i +: 8] == Marker) f[8*i +: 8] = 8'($urandom_range(3, 255));
    end else if (kind >= 85 && kind < 92) begin
      f[8*$urandom_range(0, FrameBytes - 1) +: 8] = Marker;
    end else if (kind >= 92) begin
      f = 56'({$urandom, $urandom});
    end
    return f;
  endfunction

  frame_row_t directed [$];
  frame_row_t none_row;

  initial begin
    frame_row_t row;
    for (int i = 0; i < FrameBytes; i++) frame_copy[i] = '0;
    yellow_own = 0;
    none_row = '{default: '0};

    // After reset, no marker: stored frame is all zeros, so both targets sit
    // at (0,0) and the walls read full scale.
    row = '{frame: '0, typed: 1, pin_angle: 0,
            res: '{own_v: 1, own_ang: 0, own_dist: 16'd46341, opp_v: 1, opp_ang: 0,
                   opp_dist: 16'd46341, lw_v: 1, lw_off: 9'h080, rw_v: 1,
                   rw_off: 8'h80, mf: 0}};
    directed.push_back(row);
    // Everything invalid.
    row = '{frame: pack_frame(Marker, 255, 255, 255, 255, 255, 255), typed: 1,
            pin_angle: 1, res: '{default: '0}};
    row.res.mf = 1;
    directed.push_back(row);
    // Zero vector at the centre.
    row = '{frame: pack_frame(Marker, 128, 128, 128, 128, 128, 128), typed: 1,
            pin_angle: 1,
            res: '{own_v: 1, own_ang: ZeroBearing, own_dist: 0, opp_v: 1,
                   opp_ang: ZeroBearing, opp_dist: 0, lw_v: 1, lw_off: 0, rw_v: 1,
                   rw_off: 0, mf: 1}};
    directed.push_back(row);
    // Predictor-checked rows: extremes, axes, each marker position,
    // several markers, no marker after a good frame.
    row = none_row;
    row.frame = pack_frame(Marker, 0, 0, 254, 254, 0, 254);          directed.push_back(row);
    row.frame = pack_frame(Marker, 128, 0, 128, 254, 1, 1);          directed.push_back(row);
    row.frame = pack_frame(Marker, 0, 128, 254, 128, 254, 0);        directed.push_back(row);
    row.frame = pack_frame(Marker, 254, 0, 0, 254, 127, 128);        directed.push_back(row);
    row.frame = pack_frame(Marker, 255, 10, 10, 255, 255, 7);        directed.push_back(row);
    for (int p = 1; p < FrameBytes; p++) begin
      row.frame = 56'({$urandom, $urandom});
      for (int i = 0; i < FrameBytes; i++)
        if (row.frame[8*i +: 8] == Marker) row.frame[8*i +: 8] = 8'd200;
      row.frame[8*p +: 8] = Marker;
      directed.push_back(row);
    end
    row.frame = pack_frame(Marker, 40, Marker, 90, 200, Marker, 17);  directed.push_back(row);
    row.frame = pack_frame(9, 9, 9, 9, 9, 9, 9);                      directed.push_back(row);
    row.frame = pack_frame(Marker, 129, 127, 127, 129, 128, 129);     directed.push_back(row);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass with each goal assignment.
    write_reg(RegYellow, 0);
    foreach (directed[k]) send_frame(directed[k].frame, directed[k], 1);
    write_reg(RegYellow, 1);
    for (int k = 3; k < directed.size(); k++) send_frame(directed[k].frame, none_row, 0);

    // Random phases, alternating the goal swap; long receiver hold in phase 1.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegYellow, {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, 1'(ph % 2)});
      for (int n = 0; n < 125; n++) begin
        if (ph == 1 && n == 10) hold_go = 1;
        send_frame(random_frame(), none_row, 0);
      end
    end
    s_tvalid <= 1'b0;

    while (targets_q.size() != 0) @(posedge clk);
    repeat (LatencyCycles * 2) @(posedge clk);

    $display("Sent %0d frames (%0d without a marker), checked %0d results,",
             frames_sent, frames_unmarked, results_seen);
    $display("across %0d goal-swap register writes.", cfg_writes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout: %0d results still expected", targets_q.size());
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> files.f
design/cfpt_pkg.sv
design/cfpt_ctrl.sv
design/cfpt_dp.sv
design/camera_frame_to_polar_targets_top.sv
dv/camera_frame_to_polar_targets_top_tb.sv
